// ----- rtl/sjss_pkg.sv -----
// ----------------------------------------------------------------------------
// sjss_pkg
// Shared types, constants and byte-class helpers for the Shift-JIS aware
// substring search block.
// ----------------------------------------------------------------------------
package sjss_pkg;

    // sizing
    localparam int PATTERN_MAX    = 32;
    localparam int POSITION_BITS  = 20;
    localparam int CFG_WORDS      = 4;
    localparam int WORD_BITS      = 64;
    localparam int CFG_BYTES      = CFG_WORDS * WORD_BITS / 8;
    localparam int LEN_FIELD_BITS = 6;
    localparam int LEN_BITS       = $clog2(PATTERN_MAX + 1);
    localparam int PAT_GROUPS     = (PATTERN_MAX + 7) / 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_0    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_1    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_2    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_3    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CASE_FOLD = 3'd5;

    typedef logic [POSITION_BITS-1:0] t_pos;

    // one classified text byte on its way from front to back
    typedef struct packed {
        logic [7:0] cbyte;  // byte after optional folding
        logic       trail;  // byte is the second half of a double-byte char
        logic       zero;   // terminator byte
        logic       eot;    // last byte of the string
        t_pos       pos;    // offset of this byte, saturating
    } t_token;

    // pattern compare table, prepared from the configuration registers
    typedef struct packed {
        logic [PATTERN_MAX-1:0][7:0] cmp;
        logic [PATTERN_MAX-1:0]      en;
        logic [PATTERN_MAX-1:0]      len_hot;
        logic                        len_zero;
        t_pos                        len_m1;
    } t_match_cfg;

    typedef struct packed {
        logic [FIFO_CNT_BITS-1:0] count;
        logic                     full;
        logic                     empty;
    } t_fifo_status;

    // lead byte of a double-byte character
    function automatic logic is_lead(input logic [7:0] c);
        return ((c >= 8'h81) && (c <= 8'h9F)) || ((c >= 8'hE0) && (c <= 8'hFC));
    endfunction

    function automatic logic [7:0] upper_ascii(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

endpackage

// ----- rtl/sjis_substring_search.sv -----
// ----------------------------------------------------------------------------
// sjis_substring_search
// Shift-JIS aware first-occurrence substring search over a text byte stream.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle while no back-pressure from
// the output holds it off, and gives one result per string: found with the
// offset of the first match, or not-found when a zero byte or an end_of_text
// byte closes the string. A byte passes the front register, a four-entry
// token queue and the Shift-And engine, whose parallel compare against every
// pattern byte sets the rate; the engine writes the result into the output
// register. Configuration writes land in the configuration registers and
// then reach the registered pattern compare table.
module sjis_substring_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_end_of_text,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [sjss_pkg::POSITION_BITS-1:0]  o_match_start,
    input  logic                                i_cfg_wen,
    input  logic [sjss_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [sjss_pkg::WORD_BITS-1:0]      i_cfg_data
);
    import sjss_pkg::*;

    logic         case_fold;
    t_match_cfg   match_cfg;
    logic         f_tok_valid;
    logic         f_tok_ready;
    t_token       f_token;
    logic         q_tok_valid;
    logic         q_tok_ready;
    t_token       q_token;
    t_fifo_status q_status;

    // configuration and compare table
    sjss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_case_fold (case_fold),
        .o_match_cfg (match_cfg)
    );

    // byte classification
    sjss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_case_fold   (case_fold),
        .o_tok_valid   (f_tok_valid),
        .i_tok_ready   (f_tok_ready),
        .o_token       (f_token)
    );

    // token queue
    sjss_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_tok_valid),
        .o_push_ready (f_tok_ready),
        .i_push_token (f_token),
        .o_pop_valid  (q_tok_valid),
        .i_pop_ready  (q_tok_ready),
        .o_pop_token  (q_token),
        .o_status     (q_status)
    );

    // match engine
    sjss_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (q_tok_valid),
        .o_tok_ready   (q_tok_ready),
        .i_token       (q_token),
        .i_match_cfg   (match_cfg),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_match_start (o_match_start)
    );

    // queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("token queue count beyond depth");

    // queue drains only when it holds a token
    a_fifo_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_tok_valid && q_tok_ready) |-> (q_status.count != '0))
        else $error("token queue popped while empty");

    // a not-found result carries a zero offset
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_start == '0))
        else $error("not-found result with nonzero offset");

    // reset clears the output valid
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ----- rtl/sjss_cfg.sv -----
// ----------------------------------------------------------------------------
// sjss_cfg
// Configuration registers and the registered pattern compare table
// (pattern byte classes, folding, length mask).
// ----------------------------------------------------------------------------
module sjss_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [sjss_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [sjss_pkg::WORD_BITS-1:0]      i_cfg_data,
    output logic                                o_case_fold,
    output sjss_pkg::t_match_cfg                o_match_cfg
);
    import sjss_pkg::*;

    localparam int WORD_SEL_BITS = $clog2(CFG_WORDS);
    localparam int PAD_BYTES     = PAT_GROUPS * 8;

    logic [WORD_BITS-1:0]      r_word [CFG_WORDS];
    logic [LEN_FIELD_BITS-1:0] r_len_raw;
    logic                      r_case_fold;
    t_match_cfg                r_match_cfg;
    t_match_cfg                n_match_cfg;

    logic [PAD_BYTES-1:0][7:0] pbyte;
    logic [PAD_BYTES-1:0]      trail_s0;
    logic [PAD_BYTES-1:0]      trail_s1;
    logic [PAT_GROUPS-1:0]     gend0;
    logic [PAT_GROUPS-1:0]     gend1;
    logic [PAT_GROUPS:0]       gcarry;
    logic                      s0;
    logic                      s1;
    logic                      ptrail;
    logic [LEN_BITS-1:0]       len_c;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < CFG_WORDS; w++) begin
                r_word[w] <= '0;
            end
            r_len_raw   <= '0;
            r_case_fold <= 1'b1;
        end else if (i_cfg_wen) begin
            case (i_cfg_index) inside
                CFG_WORD_0, CFG_WORD_1, CFG_WORD_2, CFG_WORD_3: begin
                    r_word[i_cfg_index[WORD_SEL_BITS-1:0]] <= i_cfg_data;
                end
                CFG_LENGTH: begin
                    r_len_raw <= i_cfg_data[LEN_FIELD_BITS-1:0];
                end
                CFG_CASE_FOLD: begin
                    r_case_fold <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp the length to the pattern capacity
    assign len_c = (int'(r_len_raw) > PATTERN_MAX) ? LEN_BITS'(PATTERN_MAX)
                                                   : LEN_BITS'(r_len_raw);

    // pattern byte classes: trail flags by groups of eight, both carry-ins,
    // then a short select chain across the groups
    always_comb begin
        for (int i = 0; i < PAD_BYTES; i++) begin
            if (i < CFG_BYTES) begin
                pbyte[i] = r_word[(i / 8) % CFG_WORDS][(i % 8) * 8 +: 8];
            end else begin
                pbyte[i] = 8'h00;
            end
        end
        s0 = 1'b0;
        s1 = 1'b0;
        for (int g = 0; g < PAT_GROUPS; g++) begin
            s0 = 1'b0;
            s1 = 1'b1;
            for (int k = 0; k < 8; k++) begin
                trail_s0[g * 8 + k] = s0;
                trail_s1[g * 8 + k] = s1;
                s0 = !s0 && is_lead(pbyte[g * 8 + k]);
                s1 = !s1 && is_lead(pbyte[g * 8 + k]);
            end
            gend0[g] = s0;
            gend1[g] = s1;
        end
        gcarry[0] = 1'b0;
        for (int g = 0; g < PAT_GROUPS; g++) begin
            gcarry[g + 1] = gcarry[g] ? gend1[g] : gend0[g];
        end
        ptrail = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            ptrail = gcarry[i / 8] ? trail_s1[i] : trail_s0[i];
            if (!ptrail && !is_lead(pbyte[i]) && r_case_fold) begin
                n_match_cfg.cmp[i] = upper_ascii(pbyte[i]);
            end else begin
                n_match_cfg.cmp[i] = pbyte[i];
            end
            n_match_cfg.en[i]      = (i < int'(len_c)) && (pbyte[i] != 8'h00);
            n_match_cfg.len_hot[i] = (int'(len_c) == (i + 1));
        end
        n_match_cfg.len_zero = (len_c == '0);
        n_match_cfg.len_m1   = (len_c == '0) ? '0 : (t_pos'(len_c) - t_pos'(1));
    end

    // compare table register
    always_ff @(posedge i_clk) begin
        r_match_cfg <= n_match_cfg;
    end

    assign o_case_fold = r_case_fold;
    assign o_match_cfg = r_match_cfg;

endmodule

// ----- rtl/sjss_front.sv -----
// ----------------------------------------------------------------------------
// sjss_front
// Accepts text bytes, tracks lead/trail status and byte offset, folds
// single-byte letters and hands a classified token to the queue.
// ----------------------------------------------------------------------------
module sjss_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    input  logic             i_case_fold,
    output logic             o_tok_valid,
    input  logic             i_tok_ready,
    output sjss_pkg::t_token o_token
);
    import sjss_pkg::*;

    logic   r_f_valid;
    logic   r_prev_lead;
    t_pos   r_pos;
    t_token r_token;
    t_token n_token;
    logic   accept;
    logic   lead;

    assign o_in_ready = !r_f_valid || i_tok_ready;
    assign accept     = i_in_valid && o_in_ready;

    // classify the incoming byte
    always_comb begin
        n_token.trail = r_prev_lead;
        n_token.zero  = (i_text_byte == 8'h00);
        n_token.eot   = i_end_of_text;
        n_token.pos   = r_pos;
        lead          = !r_prev_lead && is_lead(i_text_byte);
        if (i_case_fold && !r_prev_lead && !lead) begin
            n_token.cbyte = upper_ascii(i_text_byte);
        end else begin
            n_token.cbyte = i_text_byte;
        end
    end

    // string state and output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid   <= 1'b0;
            r_prev_lead <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (accept) begin
                r_f_valid <= 1'b1;
            end else if (i_tok_ready) begin
                r_f_valid <= 1'b0;
            end
            if (accept) begin
                if (n_token.zero || i_end_of_text) begin
                    r_prev_lead <= 1'b0;
                    r_pos       <= '0;
                end else begin
                    r_prev_lead <= lead;
                    if (r_pos != '1) begin
                        r_pos <= r_pos + t_pos'(1);
                    end
                end
            end
        end
    end

    // token payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_token <= n_token;
        end
    end

    assign o_tok_valid = r_f_valid;
    assign o_token     = r_token;

endmodule

// ----- rtl/sjss_fifo.sv -----
// ----------------------------------------------------------------------------
// sjss_fifo
// Short token queue between the front and back parts.
// ----------------------------------------------------------------------------
module sjss_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push_valid,
    output logic                   o_push_ready,
    input  sjss_pkg::t_token       i_push_token,
    output logic                   o_pop_valid,
    input  logic                   i_pop_ready,
    output sjss_pkg::t_token       o_pop_token,
    output sjss_pkg::t_fifo_status o_status
);
    import sjss_pkg::*;

    t_token                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic                     push;
    logic                     pop;

    assign o_status.count = r_count;
    assign o_status.full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

    assign o_push_ready = !o_status.full;
    assign o_pop_valid  = !o_status.empty;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_token  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                       : r_wr_ptr + FIFO_PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                       : r_rd_ptr + FIFO_PTR_BITS'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + FIFO_CNT_BITS'(1);
            end else if (pop && !push) begin
                r_count <= r_count - FIFO_CNT_BITS'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_token;
        end
    end

endmodule

// ----- rtl/sjss_back.sv -----
// ----------------------------------------------------------------------------
// sjss_back
// Shift-And match engine: updates the partial-match vector per token and
// produces one result per string into the output register.
// ----------------------------------------------------------------------------
module sjss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tok_valid,
    output logic                        o_tok_ready,
    input  sjss_pkg::t_token            i_token,
    input  sjss_pkg::t_match_cfg        i_match_cfg,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [sjss_pkg::POSITION_BITS-1:0] o_match_start
);
    import sjss_pkg::*;

    logic [PATTERN_MAX-1:0] r_pm;
    logic                   r_done;
    logic                   r_o_valid;
    logic                   r_found;
    t_pos                   r_start;

    logic [PATTERN_MAX-1:0] n_pm;
    logic                   n_done;
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] pm_upd;
    logic                   hit;
    logic                   take;
    logic                   emit;
    logic                   res_found;
    t_pos                   res_start;
    t_pos                   hit_start;

    assign o_tok_ready = !r_o_valid || i_out_ready;
    assign take        = i_tok_valid && o_tok_ready;

    // parallel compare and vector update
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            eq[i] = i_match_cfg.en[i] && (i_match_cfg.cmp[i] == i_token.cbyte);
        end
        pm_upd = PATTERN_MAX'({r_pm, !i_token.trail}) & eq;
        if (i_match_cfg.len_zero) begin
            hit = !i_token.trail;
        end else begin
            hit = |(pm_upd & i_match_cfg.len_hot);
        end
    end

    // match start, saturating
    always_comb begin
        if (i_match_cfg.len_zero || (i_token.pos == '1)) begin
            hit_start = i_token.pos;
        end else if (i_token.pos >= i_match_cfg.len_m1) begin
            hit_start = i_token.pos - i_match_cfg.len_m1;
        end else begin
            hit_start = '0;
        end
    end

    // per-string result decision
    always_comb begin
        n_pm      = r_pm;
        n_done    = r_done;
        emit      = 1'b0;
        res_found = 1'b0;
        res_start = '0;
        if (i_token.zero) begin
            emit   = !r_done;
            n_pm   = '0;
            n_done = 1'b0;
        end else if (r_done) begin
            if (i_token.eot) begin
                n_pm   = '0;
                n_done = 1'b0;
            end
        end else begin
            n_pm = pm_upd;
            if (hit) begin
                emit      = 1'b1;
                res_found = 1'b1;
                res_start = hit_start;
                n_done    = 1'b1;
            end
            if (i_token.eot) begin
                if (!hit) begin
                    emit = 1'b1;
                end
                n_pm   = '0;
                n_done = 1'b0;
            end
        end
    end

    // match state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm      <= '0;
            r_done    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pm   <= n_pm;
                r_done <= n_done;
            end
            if (take && emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_found <= res_found;
            r_start <= res_start;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_found       = r_found;
    assign o_match_start = r_start;

endmodule

// ----- test/tb_sjis_substring_search.sv -----
// ----------------------------------------------------------------------------
// tb_sjis_substring_search
// Self-checking testbench for the Shift-JIS aware substring search block.
// ----------------------------------------------------------------------------
// Text bytes flow in through a valid/ready driver fed from a queue. Results
// flow out to a monitor with random back-pressure. A byte-level search model
// tracks the Shift-And vector, lead/trail state and the saturating position,
// and it predicts one result per string. Each phase loads a new pattern setup
// while the block is idle. Directed strings cover the corner cases first.
// Random strings with embedded pattern copies follow.
// ----------------------------------------------------------------------------
module tb_sjis_substring_search;
    timeunit 1ns;
    timeprecision 1ps;

    import sjss_pkg::*;

    localparam int   CYCLE_LIMIT = 4_000_000;
    localparam int   DRAIN_CYCLES = 16;
    localparam t_pos POS_LIMIT = '1;

    typedef struct packed {
        logic [7:0] text;
        logic       eot;
    } t_text_item;

    typedef struct packed {
        logic found;
        t_pos start;
    } t_search_result;

    // dut ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [7:0]                i_text_byte = 8'h00;
    logic                      i_end_of_text = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b1;
    logic                      o_found;
    t_pos                      o_match_start;
    logic                      i_cfg_wen = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_WORD_0;
    logic [WORD_BITS-1:0]      i_cfg_data = '0;

    // stimulus and expected results
    t_text_item     byte_queue [$];
    t_search_result match_queue [$];
    t_text_item     drive_item;

    // model copy of configuration and string state
    logic [WORD_BITS-1:0]   pat_word [CFG_WORDS];
    logic [LEN_FIELD_BITS-1:0] pat_len = '0;
    logic                   fold_en = 1'b1;
    logic [PATTERN_MAX-1:0] partial_vec = '0;
    logic                   prev_lead = 1'b0;
    t_pos                   byte_pos = '0;
    logic                   str_matched = 1'b0;

    // bookkeeping
    bit byte_taken = 1'b0;
    bit quiet = 1'b0;
    bit send_burst = 1'b1;
    bit recv_burst = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int results_cnt = 0;
    int hits_cnt = 0;
    int phase_cnt = 0;
    int errors = 0;
    int cycles = 0;

    sjis_substring_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_match_start (o_match_start),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // lead byte of a double-byte character
    function automatic logic sjis_lead(input logic [7:0] c);
        return (c inside {[8'h81:8'h9F]}) || (c inside {[8'hE0:8'hFC]});
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
            return c - 8'h20;
        return c;
    endfunction

    function automatic logic ascii_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void clear_string();
        partial_vec = '0;
        prev_lead = 1'b0;
        byte_pos = '0;
        str_matched = 1'b0;
    endfunction

    function automatic void post_result(input logic found, input t_pos start);
        t_search_result r;
        r.found = found;
        r.start = start;
        match_queue.push_back(r);
    endfunction

    // one text byte through the search model
    function automatic void search_step(input logic [7:0] b, input logic eot);
        logic                   trail, lead, hit, pend_trail;
        logic [7:0]             cb, p;
        logic [PATTERN_MAX-1:0] eq;
        int                     len;
        t_pos                   start;
        hit = 1'b0;
        pend_trail = 1'b0;
        eq = '0;
        start = '0;
        // terminator closes the string without a compare
        if (b == 8'h00) begin
            if (!str_matched)
                post_result(1'b0, '0);
            clear_string();
            return;
        end
        // already matched: wait for the end of the string
        if (str_matched) begin
            if (eot)
                clear_string();
            return;
        end
        trail = prev_lead;
        lead = !trail && sjis_lead(b);
        cb = (fold_en && !trail && !lead) ? fold_upper(b) : b;
        len = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
        if (len == 0) begin
            // empty pattern hits on any boundary byte
            partial_vec = '0;
            if (!trail) begin
                hit = 1'b1;
                start = byte_pos;
            end
        end else begin
            // pattern side keeps its own lead/trail tracking
            for (int i = 0; i < len; i++) begin
                p = pat_word[i / 8][(i % 8) * 8 +: 8];
                if (pend_trail)
                    pend_trail = 1'b0;
                else if (sjis_lead(p))
                    pend_trail = 1'b1;
                else if (fold_en)
                    p = fold_upper(p);
                if (p != 8'h00 && p == cb)
                    eq[i] = 1'b1;
            end
            partial_vec = {partial_vec[PATTERN_MAX-2:0], !trail} & eq;
            if (partial_vec[len-1]) begin
                hit = 1'b1;
                if (byte_pos == POS_LIMIT)
                    start = POS_LIMIT;
                else if (byte_pos >= t_pos'(len - 1))
                    start = byte_pos - t_pos'(len - 1);
                else
                    start = '0;
            end
        end
        if (hit) begin
            post_result(1'b1, start);
            str_matched = 1'b1;
        end
        if (byte_pos != POS_LIMIT)
            byte_pos = byte_pos + 1'b1;
        prev_lead = lead;
        if (eot) begin
            if (!hit)
                post_result(1'b0, '0);
            clear_string();
        end
    endfunction

    // text byte driver, changes at the falling edge
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            send_burst = !send_burst;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !byte_taken) begin
            // hold the pending transfer
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
            drive_item = byte_queue.pop_front();
            i_text_byte <= drive_item.text;
            i_end_of_text <= drive_item.eot;
            i_in_valid <= 1'b1;
            if (!quiet && send_burst && $urandom_range(0, 4) == 0)
                send_gap = $urandom_range(1, 13);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0)
            recv_burst = !recv_burst;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && recv_burst && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 13);
        end
    end

    // monitor: input transfers feed the model, output transfers are checked
    always @(posedge i_clk) begin
        t_search_result exp_r;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                byte_taken = 1'b1;
                accepted_cnt++;
                search_step(i_text_byte, i_end_of_text);
            end
            if (o_out_valid && i_out_ready) begin
                results_cnt++;
                if (match_queue.size() == 0) begin
                    $display("%0t: unexpected result found=%0b match_start=%0d",
                             $time, o_found, o_match_start);
                    errors++;
                end else begin
                    exp_r = match_queue.pop_front();
                    if (exp_r.found)
                        hits_cnt++;
                    if (o_found !== exp_r.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, exp_r.found, o_found);
                        errors++;
                    end
                    if (o_match_start !== exp_r.start) begin
                        $display("%0t: match_start expected %0d actual %0d",
                                 $time, exp_r.start, o_match_start);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [WORD_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_WORD_0:    pat_word[0] = data;
            CFG_WORD_1:    pat_word[1] = data;
            CFG_WORD_2:    pat_word[2] = data;
            CFG_WORD_3:    pat_word[3] = data;
            CFG_LENGTH:    pat_len = data[LEN_FIELD_BITS-1:0];
            CFG_CASE_FOLD: fold_en = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        repeat (4) @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eot);
        t_text_item it;
        it.text = b;
        it.eot = eot;
        byte_queue.push_back(it);
        pushed_cnt++;
    endtask

    task automatic push_text(input string s, input bit eot_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    // sender holds off until every transfer is taken and every result is back
    task automatic settle();
        while (accepted_cnt != pushed_cnt || match_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        phase_cnt++;
    endtask

    // byte mix skewed toward letters and class boundaries
    function automatic logic [7:0] pick_sjis_byte(input bit allow_zero);
        if (allow_zero && $urandom_range(0, 39) == 0)
            return 8'h00;
        case ($urandom_range(0, 11))
            0, 1, 2: return 8'h61 + 8'($urandom_range(0, 2));
            3, 4:    return 8'h41 + 8'($urandom_range(0, 2));
            5, 6: begin
                case ($urandom_range(0, 13))
                    0:  return 8'h80;
                    1:  return 8'h81;
                    2:  return 8'h9F;
                    3:  return 8'hA0;
                    4:  return 8'hDF;
                    5:  return 8'hE0;
                    6:  return 8'hFC;
                    7:  return 8'hFD;
                    8:  return 8'h60;
                    9:  return 8'h7A;
                    10: return 8'h7B;
                    11: return 8'h40;
                    12: return 8'h5A;
                    default: return 8'hFF;
                endcase
            end
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // new random setup, then random strings
    task automatic random_phase(input int n_items, input int forced_len);
        logic [WORD_BITS-1:0] w [CFG_WORDS];
        logic [7:0]           str_bytes [$];
        logic [7:0]           b;
        int                   len, eff, base, r;
        for (int k = 0; k < CFG_WORDS; k++)
            for (int j = 0; j < 8; j++)
                w[k][j*8 +: 8] = ($urandom_range(0, 19) == 0) ? 8'h00 : pick_sjis_byte(0);
        if (forced_len >= 0) begin
            len = forced_len;
        end else begin
            case ($urandom_range(0, 15))
                0:                   len = 0;
                1, 2, 3, 4, 5, 6, 7: len = $urandom_range(1, 4);
                8, 9, 10, 11:        len = $urandom_range(5, 12);
                12, 13:              len = $urandom_range(13, 32);
                14:                  len = PATTERN_MAX;
                default:             len = $urandom_range(33, 63);
            endcase
        end
        cfg_write(CFG_WORD_0, w[0]);
        cfg_write(CFG_WORD_1, w[1]);
        cfg_write(CFG_WORD_2, w[2]);
        cfg_write(CFG_WORD_3, w[3]);
        // upper data bits are don't care for the narrow registers
        cfg_write(CFG_LENGTH, {$urandom, $urandom} & ~64'h3F | 64'(len));
        cfg_write(CFG_CASE_FOLD, {$urandom, $urandom} & ~64'h1 | 64'($urandom_range(0, 1)));
        eff = (len > PATTERN_MAX) ? PATTERN_MAX : len;
        base = pushed_cnt;
        while (pushed_cnt - base < n_items) begin
            str_bytes.delete();
            repeat ($urandom_range(0, 12))
                str_bytes.push_back(pick_sjis_byte(1));
            // embedded pattern copy, letters in random case when folding
            if ($urandom_range(0, 9) < 7) begin
                for (int i = 0; i < eff; i++) begin
                    b = pat_word[i / 8][(i % 8) * 8 +: 8];
                    if (b == 8'h00)
                        b = pick_sjis_byte(0);
                    if (fold_en && ascii_letter(b) && $urandom_range(0, 1) == 1)
                        b = b ^ 8'h20;
                    str_bytes.push_back(b);
                end
            end
            repeat ($urandom_range(0, 6))
                str_bytes.push_back(pick_sjis_byte(1));
            r = $urandom_range(0, 9);
            if (r < 6) begin
                // end mark on the last byte
                if (str_bytes.size() == 0)
                    str_bytes.push_back(pick_sjis_byte(0));
                for (int i = 0; i < str_bytes.size(); i++)
                    push_byte(str_bytes[i], i == str_bytes.size() - 1);
            end else begin
                foreach (str_bytes[i])
                    push_byte(str_bytes[i], 1'b0);
                // terminator byte, or the string runs into the next one
                if (r < 9)
                    push_byte(8'h00, 1'($urandom_range(0, 1)));
            end
        end
        settle();
    endtask

    // test sequence
    initial begin
        for (int k = 0; k < CFG_WORDS; k++)
            pat_word[k] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset setup: empty pattern, folding on
        push_text("A", 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(8'h40, 1'b1);
        settle();

        // pattern "ab", folding on, upper words all ones
        cfg_write(CFG_WORD_0, 64'h6261);
        cfg_write(CFG_WORD_1, '1);
        cfg_write(CFG_WORD_2, '1);
        cfg_write(CFG_WORD_3, '1);
        cfg_write(CFG_LENGTH, 64'd2);
        push_text("xAB", 1'b1);
        // letters after a lead byte are trail bytes and stay raw
        push_byte(8'h82, 1'b0);
        push_text("ab", 1'b1);
        // bytes after a match give nothing, terminator closes silently
        push_text("abc", 1'b0);
        push_byte(8'h00, 1'b0);
        // string left open across a setup change keeps its partial match
        push_text("xa", 1'b0);
        settle();
        cfg_write(CFG_CASE_FOLD, 64'd0);
        push_text("b", 1'b1);
        // raw compare
        push_text("AB", 1'b1);
        push_text("ab", 1'b1);
        settle();

        // double-byte pattern, folding on
        cfg_write(CFG_WORD_0, 64'h6182);
        cfg_write(CFG_CASE_FOLD, 64'd1);
        push_byte(8'h82, 1'b0);
        push_text("a", 1'b1);
        push_byte(8'h82, 1'b0);
        push_text("A", 1'b1);
        settle();

        // zero byte inside the pattern never matches
        cfg_write(CFG_WORD_0, 64'h620061);
        cfg_write(CFG_LENGTH, 64'd3);
        push_text("ab", 1'b1);
        settle();

        // random setups, no idling in the last ones
        for (int ph = 0; ph < 12; ph++) begin
            if (ph >= 10)
                quiet = 1'b1;
            random_phase(140, (ph == 0) ? PATTERN_MAX : (ph == 1) ? 63 : (ph == 2) ? 1 : -1);
        end

        if (match_queue.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, match_queue.size());
            errors++;
        end
        $display("run covered %0d text bytes over %0d setups", accepted_cnt, phase_cnt);
        $display("%0d results checked, %0d of them matches, %0d errors",
                 results_cnt, hits_cnt, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
